// ===== rtl/core/pdu_pkg.sv =====
// Shared types, register codes and constants of the particle dimension update.
package pdu_pkg;

  // Data widths
  localparam int DATA_W  = 32;   // signed Q8.24 values
  localparam int REG_W   = 31;   // unsigned Q7.24 registers
  localparam int RAND_W  = 16;
  localparam int FRAC_W  = 24;
  localparam int IDX_W   = 3;    // configuration register index
  localparam int SEL_W   = 2;
  localparam int NUM_BOUND_REGS = 3;

  // Default dimension count
  localparam int DIMENSIONS_DEFAULT = 3;

  // Magnitude of the clamped step and its tenth
  localparam int MAG_W   = 38;   // limit = (umax * bound) >> 24 fits 38 bits
  localparam int QUOT_W  = 35;   // 2^38 / 10 < 2^35
  localparam int MAG_LO_W = MAG_W / 2;
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;

  // Reciprocal of ten: floor(n * RECIP / 2^SHIFT) == floor(n / 10) for n < 2^MAG_W
  localparam int DIV10_SHIFT = MAG_W + 4;
  localparam int RECIP_W     = MAG_W + 1;
  localparam logic [RECIP_W-1:0] DIV10_RECIP =
    RECIP_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_INERTIA   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOCIAL    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COGNITIVE = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOUND0    = 3'd4;

  // Register reset values
  localparam logic [REG_W-1:0] INERTIA_RESET   = 31'd10066330;  // 0.6
  localparam logic [REG_W-1:0] SOCIAL_RESET    = 31'd33554432;  // 2.0
  localparam logic [REG_W-1:0] COGNITIVE_RESET = 31'd33554432;  // 2.0
  localparam logic [REG_W-1:0] SPEED_RESET     = 31'd3355443;   // 0.2
  localparam logic [REG_W-1:0] BOUND_RESET     = 31'd16777216;  // 1.0

  // Bound hit codes
  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_UPPER = 2'd1;
  localparam logic [1:0] HIT_LOWER = 2'd2;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Input item
  typedef struct packed {
    logic [SEL_W-1:0]         dim_select;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] global_best;
    logic signed [DATA_W-1:0] personal_best;
    logic [RAND_W-1:0]        rand_social;
    logic [RAND_W-1:0]        rand_cognitive;
  } item_t;

  // Result item
  typedef struct packed {
    logic signed [DATA_W-1:0] new_position;
    logic signed [DATA_W-1:0] new_velocity;
    logic                     speed_limited;
    logic [1:0]               bound_hit;
  } result_t;

endpackage

// ===== rtl/core/pso_particle_dimension_update.sv =====
// Top level: pipelined particle swarm velocity and position update of one dimension.
//
//  channel   | signals                               | direction | transfer when
//  ----------+---------------------------------------+-----------+-------------------------
//  item      | item_valid, item_stall, item          | in        | item_valid & !item_stall
//  result    | result_valid, result_stall, result    | out       | result_valid & !result_stall
//  config    | cfg_wr_en, cfg_index, cfg_data        | in        | cfg_wr_en
//
// Six register stages take one item per cycle while result_stall is low; stage depth
// is set by the 31x33 bit products and the reciprocal multiply for the tenth of the step.
// A stage loads whenever it is empty or the one after it moves, so bubbles close up
// and item_stall follows result_stall only while the whole pipe is full.
// rst (synchronous) empties the pipe, holds item_stall high and restores the
// register defaults.
module pso_particle_dimension_update #(
  parameter int DIMENSIONS = pdu_pkg::DIMENSIONS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  pdu_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output pdu_pkg::result_t               result,
  input  logic                           cfg_wr_en,
  input  logic [pdu_pkg::IDX_W-1:0]      cfg_index,
  input  logic [pdu_pkg::REG_W-1:0]      cfg_data
);

  localparam int NUM_BOUNDS = (DIMENSIONS < pdu_pkg::NUM_BOUND_REGS) ?
                              DIMENSIONS : pdu_pkg::NUM_BOUND_REGS;
  localparam int LAST_BOUND = NUM_BOUNDS - 1;

  localparam int DW  = pdu_pkg::DATA_W;
  localparam int RW  = pdu_pkg::REG_W;
  localparam int FW  = pdu_pkg::FRAC_W;
  localparam int MW  = pdu_pkg::MAG_W;
  localparam int WVP_W = RW + DW;          // inertia product
  localparam int WVT_W = WVP_W - FW;
  localparam int DIF_W = DW + 1;           // g - x, p - x
  localparam int TP_W  = RW + DIF_W;       // attraction products
  localparam int TT_W  = TP_W - FW;
  localparam int U_W   = TT_W + 2;         // sum of three terms
  localparam int UC_W  = MW + 1;           // clamped step
  localparam int SUM_W = MW + 2;           // x + clamped step
  localparam int KP_W  = RW + pdu_pkg::RAND_W;
  localparam int LP_W  = 2 * RW;

  // Configuration registers
  logic [RW-1:0] inertia_weight;
  logic [RW-1:0] social_coeff;
  logic [RW-1:0] cognitive_coeff;
  logic [RW-1:0] speed_fraction;
  logic [RW-1:0] bound_regs [NUM_BOUNDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight  <= pdu_pkg::INERTIA_RESET;
      social_coeff    <= pdu_pkg::SOCIAL_RESET;
      cognitive_coeff <= pdu_pkg::COGNITIVE_RESET;
      speed_fraction  <= pdu_pkg::SPEED_RESET;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bound_regs[i] <= pdu_pkg::BOUND_RESET;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == pdu_pkg::REG_INERTIA)   inertia_weight  <= cfg_data;
      if (cfg_index == pdu_pkg::REG_SOCIAL)    social_coeff    <= cfg_data;
      if (cfg_index == pdu_pkg::REG_COGNITIVE) cognitive_coeff <= cfg_data;
      if (cfg_index == pdu_pkg::REG_SPEED)     speed_fraction  <= cfg_data;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        if (cfg_index == pdu_pkg::REG_BOUND0 + pdu_pkg::IDX_W'(i)) begin
          bound_regs[i] <= cfg_data;
        end
      end
    end
  end

  // Pipeline control: a stage moves when empty or when its successor moves
  logic [6:1] vld;
  logic [6:1] adv;

  always_comb begin
    adv[6] = !vld[6] || !result_stall;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign item_stall   = rst || !adv[1];
  assign result_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= item_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: bound select, coefficients, inertia product, differences, speed limit
  logic [RW-1:0]           bound_sel;
  logic [KP_W-1:0]         ks_prod;
  logic [KP_W-1:0]         kc_prod;
  logic signed [WVP_W-1:0] w_ext;
  logic signed [WVP_W-1:0] v_ext;
  logic signed [WVP_W-1:0] wv_prod;
  logic [LP_W-1:0]         lim_prod;

  always_comb begin
    bound_sel = bound_regs[LAST_BOUND];
    for (int i = 0; i < LAST_BOUND; i++) begin
      if (item.dim_select == pdu_pkg::SEL_W'(i)) bound_sel = bound_regs[i];
    end
    ks_prod  = KP_W'(social_coeff) * KP_W'(item.rand_social);
    kc_prod  = KP_W'(cognitive_coeff) * KP_W'(item.rand_cognitive);
    w_ext    = {{(WVP_W-RW){1'b0}}, inertia_weight};
    v_ext    = {{(WVP_W-DW){item.velocity[DW-1]}}, item.velocity};
    wv_prod  = w_ext * v_ext;
    lim_prod = LP_W'(speed_fraction) * LP_W'(bound_sel);
  end

  logic [RW-1:0]           s1_ks;
  logic [RW-1:0]           s1_kc;
  logic signed [WVT_W-1:0] s1_wv;
  logic signed [DIF_W-1:0] s1_dg;
  logic signed [DIF_W-1:0] s1_dp;
  logic signed [DW-1:0]    s1_x;
  logic [MW-1:0]           s1_limit;
  logic [RW-1:0]           s1_bound;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_ks    <= ks_prod[KP_W-1:pdu_pkg::RAND_W];
      s1_kc    <= kc_prod[KP_W-1:pdu_pkg::RAND_W];
      s1_wv    <= wv_prod[WVP_W-1:FW];
      s1_dg    <= {item.global_best[DW-1], item.global_best} -
                  {item.position[DW-1], item.position};
      s1_dp    <= {item.personal_best[DW-1], item.personal_best} -
                  {item.position[DW-1], item.position};
      s1_x     <= item.position;
      s1_limit <= lim_prod[FW +: MW];
      s1_bound <= bound_sel;
    end
  end

  // Stage 2: social and cognitive products, floor-shifted
  logic signed [TP_W-1:0] ks_ext;
  logic signed [TP_W-1:0] kc_ext;
  logic signed [TP_W-1:0] dg_ext;
  logic signed [TP_W-1:0] dp_ext;
  logic signed [TP_W-1:0] soc_prod;
  logic signed [TP_W-1:0] cog_prod;

  always_comb begin
    ks_ext   = {{(TP_W-RW){1'b0}}, s1_ks};
    kc_ext   = {{(TP_W-RW){1'b0}}, s1_kc};
    dg_ext   = {{(TP_W-DIF_W){s1_dg[DIF_W-1]}}, s1_dg};
    dp_ext   = {{(TP_W-DIF_W){s1_dp[DIF_W-1]}}, s1_dp};
    soc_prod = ks_ext * dg_ext;
    cog_prod = kc_ext * dp_ext;
  end

  logic signed [WVT_W-1:0] s2_wv;
  logic signed [TT_W-1:0]  s2_soc;
  logic signed [TT_W-1:0]  s2_cog;
  logic signed [DW-1:0]    s2_x;
  logic [MW-1:0]           s2_limit;
  logic [RW-1:0]           s2_bound;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_wv    <= s1_wv;
      s2_soc   <= soc_prod[TP_W-1:FW];
      s2_cog   <= cog_prod[TP_W-1:FW];
      s2_x     <= s1_x;
      s2_limit <= s1_limit;
      s2_bound <= s1_bound;
    end
  end

  // Stage 3: proposed step u
  logic signed [U_W-1:0] s3_u;
  logic signed [DW-1:0]  s3_x;
  logic [MW-1:0]         s3_limit;
  logic [RW-1:0]         s3_bound;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_u     <= {{(U_W-WVT_W){s2_wv[WVT_W-1]}}, s2_wv} +
                  {{(U_W-TT_W){s2_soc[TT_W-1]}}, s2_soc} +
                  {{(U_W-TT_W){s2_cog[TT_W-1]}}, s2_cog};
      s3_x     <= s2_x;
      s3_limit <= s2_limit;
      s3_bound <= s2_bound;
    end
  end

  // Stage 4: magnitude and speed clamp
  logic [U_W-1:0]  u_mag;
  logic            limited;
  logic [UC_W-1:0] u_clamp;
  logic [MW-1:0]   mag_clamp;

  always_comb begin
    u_mag   = s3_u[U_W-1] ? U_W'(-s3_u) : U_W'(s3_u);
    limited = u_mag > {{(U_W-MW){1'b0}}, s3_limit};
    if (limited) begin
      u_clamp   = s3_u[U_W-1] ? -{1'b0, s3_limit} : {1'b0, s3_limit};
      mag_clamp = s3_limit;
    end else begin
      u_clamp   = s3_u[UC_W-1:0];
      mag_clamp = u_mag[MW-1:0];
    end
  end

  logic signed [UC_W-1:0] s4_u;
  logic [MW-1:0]          s4_mag;
  logic                   s4_limited;
  logic signed [DW-1:0]   s4_x;
  logic [RW-1:0]          s4_bound;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_u       <= u_clamp;
      s4_mag     <= mag_clamp;
      s4_limited <= limited;
      s4_x       <= s3_x;
      s4_bound   <= s3_bound;
    end
  end

  // Stage 5: new position, bound check, saturated velocity; tenth starts here
  logic signed [SUM_W-1:0] pos_sum;
  logic signed [SUM_W-1:0] bound_ext;
  logic [1:0]              hit;
  logic [DW-1:0]           u_sat;

  always_comb begin
    pos_sum   = {{(SUM_W-DW){s4_x[DW-1]}}, s4_x} + {s4_u[UC_W-1], s4_u};
    bound_ext = {{(SUM_W-RW){1'b0}}, s4_bound};
    if (pos_sum > bound_ext) begin
      hit = pdu_pkg::HIT_UPPER;
    end else if (pos_sum[SUM_W-1]) begin
      hit = pdu_pkg::HIT_LOWER;
    end else begin
      hit = pdu_pkg::HIT_NONE;
    end
    if (s4_u[UC_W-1:DW-1] == '0 || s4_u[UC_W-1:DW-1] == '1) begin
      u_sat = s4_u[DW-1:0];
    end else begin
      u_sat = s4_u[UC_W-1] ? pdu_pkg::SAT_MIN : pdu_pkg::SAT_MAX;
    end
  end

  logic [pdu_pkg::QUOT_W-1:0] tenth;

  pdu_div10 u_div10 (
    .clk  (clk),
    .adv  (adv[5]),
    .mag  (s4_mag),
    .quot (tenth)
  );

  logic [1:0]    s5_hit;
  logic          s5_limited;
  logic [DW-1:0] s5_pos;
  logic [DW-1:0] s5_vel;
  logic [RW-1:0] s5_bound;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_hit     <= hit;
      s5_limited <= s4_limited;
      s5_pos     <= pos_sum[DW-1:0];
      s5_vel     <= u_sat;
      s5_bound   <= s4_bound;
    end
  end

  // Stage 6: reflection select and output register
  logic          tenth_big;
  logic [DW-1:0] tenth_pos;
  logic [DW-1:0] tenth_neg;
  pdu_pkg::result_t res_next;

  always_comb begin
    tenth_big = |tenth[pdu_pkg::QUOT_W-1:DW-1];
    tenth_pos = tenth_big ? pdu_pkg::SAT_MAX : {1'b0, tenth[DW-2:0]};
    tenth_neg = tenth_big ? pdu_pkg::SAT_MIN : -{1'b0, tenth[DW-2:0]};
    res_next.speed_limited = s5_limited;
    res_next.bound_hit     = s5_hit;
    unique case (s5_hit)
      pdu_pkg::HIT_UPPER: begin
        res_next.new_position = {1'b0, s5_bound};
        res_next.new_velocity = tenth_neg;
      end
      pdu_pkg::HIT_LOWER: begin
        res_next.new_position = tenth_pos;
        res_next.new_velocity = tenth_pos;
      end
      default: begin
        res_next.new_position = s5_pos;
        res_next.new_velocity = s5_vel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/core/pdu_div10.sv =====
// Divide-by-ten of the step magnitude by reciprocal multiply, split into two partial products.
module pdu_div10 (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [pdu_pkg::MAG_W-1:0]      mag,
  output logic [pdu_pkg::QUOT_W-1:0]     quot
);

  localparam int PP_W  = pdu_pkg::MAG_HI_W + pdu_pkg::RECIP_W;
  localparam int SUM_W = pdu_pkg::MAG_W + pdu_pkg::RECIP_W;

  logic [PP_W-1:0]  pp_hi;
  logic [PP_W-1:0]  pp_lo;
  logic [SUM_W-1:0] full;

  // Partial products of the upper and lower halves, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_hi <= PP_W'(mag[pdu_pkg::MAG_W-1:pdu_pkg::MAG_LO_W]) * PP_W'(pdu_pkg::DIV10_RECIP);
      pp_lo <= PP_W'(mag[pdu_pkg::MAG_LO_W-1:0]) * PP_W'(pdu_pkg::DIV10_RECIP);
    end
  end

  // Recombine and drop the fraction
  always_comb begin
    full = (SUM_W'(pp_hi) << pdu_pkg::MAG_LO_W) + SUM_W'(pp_lo);
    quot = full[SUM_W-1 -: pdu_pkg::QUOT_W];
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the particle dimension update: directed and random items, checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int DIMS = pdu_pkg::DIMENSIONS_DEFAULT;
  localparam int LAST_DIM =
    (DIMS < pdu_pkg::NUM_BOUND_REGS ? DIMS : pdu_pkg::NUM_BOUND_REGS) - 1;
  localparam int ONE = 1 << pdu_pkg::FRAC_W;     // 1.0 in Q8.24
  localparam int VMAX = pdu_pkg::SAT_MAX;
  localparam int VMIN = pdu_pkg::SAT_MIN;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 6;
  localparam int PAUSE_AT = 75;
  localparam int TAIL_CYCLES = 12;

  typedef logic signed [95:0] wide_t;
  localparam wide_t SAT_HI = 96'sd2147483647;
  localparam wide_t SAT_LO = -96'sd2147483648;

  // Expected-update store and predictor with its own copy of the registers
  class update_checker;
    logic [pdu_pkg::REG_W-1:0] inertia, social, cognitive, speed;
    logic [pdu_pkg::REG_W-1:0] bound [pdu_pkg::NUM_BOUND_REGS];
    pdu_pkg::result_t expected_updates [$];
    int mismatch_count;

    function new();
      inertia = pdu_pkg::INERTIA_RESET;
      social = pdu_pkg::SOCIAL_RESET;
      cognitive = pdu_pkg::COGNITIVE_RESET;
      speed = pdu_pkg::SPEED_RESET;
      foreach (bound[i]) bound[i] = pdu_pkg::BOUND_RESET;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [pdu_pkg::IDX_W-1:0] idx, logic [pdu_pkg::REG_W-1:0] data);
      case (idx)
        pdu_pkg::REG_INERTIA: inertia = data;
        pdu_pkg::REG_SOCIAL: social = data;
        pdu_pkg::REG_COGNITIVE: cognitive = data;
        pdu_pkg::REG_SPEED: speed = data;
        default: begin
          if (idx >= pdu_pkg::REG_BOUND0 &&
              idx < pdu_pkg::REG_BOUND0 + pdu_pkg::NUM_BOUND_REGS)
            bound[idx - pdu_pkg::REG_BOUND0] = data;
        end
      endcase
    endfunction

    function logic signed [pdu_pkg::DATA_W-1:0] saturate(wide_t a);
      if (a > SAT_HI) return pdu_pkg::SAT_MAX;
      if (a < SAT_LO) return pdu_pkg::SAT_MIN;
      return a[pdu_pkg::DATA_W-1:0];
    endfunction

    // One velocity and position update, in exact wide arithmetic
    function pdu_pkg::result_t predict_update(pdu_pkg::item_t it);
      wide_t x, v, g, p, w, csoc, ccog, umax, bnd, rs, rc, ks, kc;
      wide_t step, lim, mag, tenth, sum, np, nv;
      int unsigned sel;
      pdu_pkg::result_t r;
      sel = it.dim_select;
      if (sel > LAST_DIM) sel = LAST_DIM;
      bnd = bound[sel];
      x = $signed(it.position);
      v = $signed(it.velocity);
      g = $signed(it.global_best);
      p = $signed(it.personal_best);
      rs = it.rand_social;
      rc = it.rand_cognitive;
      w = inertia;
      csoc = social;
      ccog = cognitive;
      umax = speed;
      ks = (csoc * rs) >>> pdu_pkg::RAND_W;
      kc = (ccog * rc) >>> pdu_pkg::RAND_W;
      step = ((w * v) >>> pdu_pkg::FRAC_W) + ((ks * (g - x)) >>> pdu_pkg::FRAC_W)
           + ((kc * (p - x)) >>> pdu_pkg::FRAC_W);
      lim = (umax * bnd) >>> pdu_pkg::FRAC_W;
      mag = (step < 0) ? -step : step;
      r.speed_limited = 1'b0;
      if (mag > lim) begin
        r.speed_limited = 1'b1;
        step = (step < 0) ? -lim : lim;
        mag = lim;
      end
      tenth = mag / 10;
      sum = x + step;
      // reflect at the bound, reflect at zero, or simply advance
      if (sum > bnd) begin
        r.bound_hit = pdu_pkg::HIT_UPPER;
        np = bnd;
        nv = -tenth;
      end else if (sum < 0) begin
        r.bound_hit = pdu_pkg::HIT_LOWER;
        np = tenth;
        nv = tenth;
      end else begin
        r.bound_hit = pdu_pkg::HIT_NONE;
        np = sum;
        nv = step;
      end
      r.new_position = saturate(np);
      r.new_velocity = saturate(nv);
      return r;
    endfunction

    function void take_item(pdu_pkg::item_t it);
      expected_updates.push_back(predict_update(it));
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_update(pdu_pkg::result_t got);
      pdu_pkg::result_t want;
      if (expected_updates.size() == 0) begin
        report_mismatch("result transfer with no update outstanding");
      end else begin
        want = expected_updates.pop_front();
        if (got.new_position !== want.new_position)
          report_mismatch($sformatf("new_position %h, wanted %h",
                                    got.new_position, want.new_position));
        if (got.new_velocity !== want.new_velocity)
          report_mismatch($sformatf("new_velocity %h, wanted %h",
                                    got.new_velocity, want.new_velocity));
        if (got.speed_limited !== want.speed_limited)
          report_mismatch($sformatf("speed_limited %b, wanted %b",
                                    got.speed_limited, want.speed_limited));
        if (got.bound_hit !== want.bound_hit)
          report_mismatch($sformatf("bound_hit %0d, wanted %0d",
                                    got.bound_hit, want.bound_hit));
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pdu_pkg::item_t item_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pdu_pkg::result_t result_data;
  logic cfg_wr_en = 1'b0;
  logic [pdu_pkg::IDX_W-1:0] cfg_index = '0;
  logic [pdu_pkg::REG_W-1:0] cfg_data = '0;

  int send_pct = 0;
  int recv_pct = 0;
  update_checker board;

  pso_particle_dimension_update #(
    .DIMENSIONS(DIMS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_pct);
  end

  // Watch both channels for transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.take_item(item_data);
      if (result_valid && !result_stall) board.check_update(result_data);
    end
  end

  function automatic pdu_pkg::item_t mk(int unsigned sel, int x, int v, int g, int p,
                                        int unsigned rs, int unsigned rc);
    pdu_pkg::item_t it;
    it.dim_select = pdu_pkg::SEL_W'(sel);
    it.position = x;
    it.velocity = v;
    it.global_best = g;
    it.personal_best = p;
    it.rand_social = pdu_pkg::RAND_W'(rs);
    it.rand_cognitive = pdu_pkg::RAND_W'(rc);
    return it;
  endfunction

  // Offer one item, with random idle cycles first, and hold it until taken
  task automatic send_item(pdu_pkg::item_t it);
    while ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding update
  task automatic wait_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write all register indexes back to back with this phase's values
  task automatic program_phase(int ph);
    logic [pdu_pkg::IDX_W-1:0] idx;
    logic [pdu_pkg::REG_W-1:0] val;
    for (int i = 0; i < (1 << pdu_pkg::IDX_W); i++) begin
      idx = pdu_pkg::IDX_W'(i);
      case (ph)
        1: val = '1;
        2: val = '0;
        4: val = pdu_pkg::REG_W'($urandom);
        default: begin
          case (idx)
            pdu_pkg::REG_INERTIA: val = pdu_pkg::REG_W'($urandom_range(0, 2 * ONE));
            pdu_pkg::REG_SOCIAL, pdu_pkg::REG_COGNITIVE:
              val = pdu_pkg::REG_W'($urandom_range(0, 4 * ONE));
            pdu_pkg::REG_SPEED: val = pdu_pkg::REG_W'($urandom_range(0, ONE));
            default: val = pdu_pkg::REG_W'($urandom_range(1, 100 * ONE));
          endcase
        end
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      board.set_reg(idx, val);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    pdu_pkg::item_t directed [$];
    pdu_pkg::item_t it;
    longint b, span;
    int unsigned sel;
    board = new();
    while (rst) @(posedge clk);

    // Directed cases under the reset register values
    directed.push_back(mk(0, ONE / 2, ONE / 20, ONE / 2, ONE / 2, 0, 0));
    directed.push_back(mk(0, ONE / 2, ONE, ONE / 2, ONE / 2, 0, 0));
    directed.push_back(mk(0, ONE / 2, -ONE, ONE / 2, ONE / 2, 0, 0));
    directed.push_back(mk(0, ONE / 2, ONE / 3, ONE / 2, ONE / 2, 0, 0));
    directed.push_back(mk(1, ONE * 95 / 100, ONE / 5, ONE, ONE, 16'hffff, 16'hffff));
    directed.push_back(mk(2, ONE / 20, -ONE / 5, 0, 0, 0, 0));
    directed.push_back(mk(3, ONE / 2, 0, ONE, 0, 16'h8000, 16'h8000));
    directed.push_back(mk(3, ONE * 99 / 100, ONE / 5, ONE, ONE, 16'h8000, 16'h8000));
    directed.push_back(mk(0, ONE, 0, ONE, ONE, 0, 0));
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(1, 1, -1, 0, 0, 0, 0));
    directed.push_back(mk(2, 0, -1, 0, 0, 0, 0));
    directed.push_back(mk(0, VMAX, VMAX, VMAX, VMAX, 16'hffff, 16'hffff));
    directed.push_back(mk(0, VMIN, VMIN, VMIN, VMIN, 16'hffff, 16'hffff));
    directed.push_back(mk(1, VMAX, VMIN, VMIN, VMAX, 16'hffff, 0));
    directed.push_back(mk(2, VMIN, VMAX, VMAX, VMIN, 0, 16'hffff));
    directed.push_back(mk(3, -1, -1, -1, -1, 16'hffff, 16'hffff));
    directed.push_back(mk(0, ONE / 2, ONE / 20, VMAX, VMIN, 16'hffff, 16'hffff));
    directed.push_back(mk(1, ONE / 2, 0, VMIN, VMAX, 16'hffff, 16'hffff));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drain();
        program_phase(ph);
      end
      case (ph)
        1, 5: begin send_pct = 60; recv_pct = 0; end
        2: begin send_pct = 0; recv_pct = 60; end
        3: begin send_pct = 24; recv_pct = 24; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      if (ph == 0) foreach (directed[i]) send_item(directed[i]);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == PAUSE_AT) wait_drain();
        if ($urandom_range(99) < 70) begin
          // well-formed: positions and bests inside the bound, modest velocity
          it.dim_select = pdu_pkg::SEL_W'($urandom_range(0, 3));
          sel = it.dim_select;
          if (sel > LAST_DIM) sel = LAST_DIM;
          b = longint'(board.bound[sel]);
          span = b / 4 + 1;
          it.position = pdu_pkg::DATA_W'(longint'($urandom) % (b + 1));
          it.velocity = pdu_pkg::DATA_W'(longint'($urandom) % (2 * span + 1) - span);
          it.global_best = pdu_pkg::DATA_W'(longint'($urandom) % (b + 1));
          it.personal_best = pdu_pkg::DATA_W'(longint'($urandom) % (b + 1));
        end else begin
          it.dim_select = pdu_pkg::SEL_W'($urandom);
          it.position = $urandom;
          it.velocity = $urandom;
          it.global_best = $urandom;
          it.personal_best = $urandom;
        end
        it.rand_social = pdu_pkg::RAND_W'($urandom);
        it.rand_cognitive = pdu_pkg::RAND_W'($urandom);
        send_item(it);
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
